// File: design/b58enc_pkg.sv
// shared constants, types and the digit-to-character map of the base58 encoder
package b58enc_pkg;

   localparam int MAX_INPUT_BYTES = 32;
   localparam int RADIX           = 58;
   localparam int BYTE_W          = 8;
   localparam int BYTE_SPAN       = 2 ** BYTE_W;

   // log(256) / log(58) scaled by 1e5, rounded up
   localparam int NUM_DIGITS = (MAX_INPUT_BYTES * 136566 + 99999) / 100000;

   localparam int BYTE_QUOT    = BYTE_SPAN / RADIX;
   localparam int BYTE_RESIDUE = BYTE_SPAN % RADIX;

   localparam int DIGIT_W  = $clog2(RADIX);
   localparam int CARRY_W  = BYTE_W;
   localparam int PART_MAX = (RADIX - 1) * BYTE_RESIDUE + BYTE_SPAN - 1;
   localparam int PART_W   = $clog2(PART_MAX + 1);

   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_MULT  = (2 ** RECIP_SHIFT + RADIX - 1) / RADIX;
   localparam int PROD_W      = PART_W + $clog2(RECIP_MULT + 1);
   localparam int QUOT_W      = $clog2(PART_MAX / RADIX + 1);

   localparam int CHAR_W    = 7;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 7;
   localparam int CFG_RESET = 64;

   localparam int BYTE_CNT_W  = $clog2(MAX_INPUT_BYTES + 1);
   localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS + 1);
   localparam int STEP_W      = $clog2(NUM_DIGITS + 2);
   localparam int SUM_W       = $clog2(MAX_INPUT_BYTES + NUM_DIGITS + 1);
   localparam int TOTAL_W     = (SUM_W > CFG_W) ? SUM_W : CFG_W;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INPUT_LONG  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OUTPUT_LONG = 2'd2;

   localparam logic [CHAR_W-1:0] ASCII_ONE     = 7'h31;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_J = 7'h4A;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_P = 7'h50;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 7'h61;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_M = 7'h6D;

   typedef logic [DIGIT_W-1:0] digit_type;

   typedef struct packed {
      logic               valid;
      logic [CARRY_W-1:0] value;
   } carry_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   function automatic logic [CHAR_W-1:0] b58_char(input digit_type d);
      logic [CHAR_W-1:0] ext;
      logic [CHAR_W-1:0] result;
      ext = CHAR_W'(d);
      if (ext < 7'd9) begin
         result = ASCII_ONE + ext;
      end else if (ext < 7'd17) begin
         result = ASCII_UPPER_A + (ext - 7'd9);
      end else if (ext < 7'd22) begin
         result = ASCII_UPPER_J + (ext - 7'd17);
      end else if (ext < 7'd33) begin
         result = ASCII_UPPER_P + (ext - 7'd22);
      end else if (ext < 7'd44) begin
         result = ASCII_LOWER_A + (ext - 7'd33);
      end else if (ext < 7'd58) begin
         result = ASCII_LOWER_M + (ext - 7'd44);
      end else begin
         result = '0;
      end
      return result;
   endfunction

endpackage

// File: design/b58enc_req_if.sv
// request channel: one byte of the string per transfer
interface b58enc_req_if;
   logic                           valid;
   logic                           ready;
   logic [b58enc_pkg::BYTE_W-1:0]  byte_value;
   logic                           last_byte;

   modport source (output valid, output byte_value, output last_byte, input ready);
   modport sink (input valid, input byte_value, input last_byte, output ready);
endinterface

// File: design/b58enc_rsp_if.sv
// response channel: one encoded character or one error per transfer
interface b58enc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [b58enc_pkg::CHAR_W-1:0]    character;
   logic                             last_char;
   logic [b58enc_pkg::STATUS_W-1:0]  status;

   modport source (output valid, output character, output last_char, output status,
                   input ready);
   modport sink (input valid, input character, input last_char, input status,
                 output ready);
endinterface

// File: design/b58enc_cell.sv
// one base-58 digit cell: multiply-by-256-and-add step, or shift to the next cell
module b58enc_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  b58enc_pkg::cell_ctrl_type ctrl,
   input  b58enc_pkg::carry_type     carry_in,
   input  b58enc_pkg::digit_type     shift_in,
   output b58enc_pkg::carry_type     carry_out,
   output b58enc_pkg::digit_type     digit
);

   b58enc_pkg::digit_type                 digit_ff, digit_in;
   b58enc_pkg::carry_type                 carry_ff, carry_in_next;
   logic [b58enc_pkg::PART_W-1:0]         part;
   logic [b58enc_pkg::PROD_W-1:0]         prod;
   logic [b58enc_pkg::QUOT_W-1:0]         quot;
   logic [b58enc_pkg::PART_W-1:0]         quot_scaled;
   b58enc_pkg::digit_type                 rem;

   // digit*256 + carry = 58*(4*digit + part/58) + part%58, part = 24*digit + carry
   always_comb begin
      part = b58enc_pkg::PART_W'(digit_ff) * b58enc_pkg::PART_W'(b58enc_pkg::BYTE_RESIDUE)
           + b58enc_pkg::PART_W'(carry_in.value);
      prod = b58enc_pkg::PROD_W'(part) * b58enc_pkg::PROD_W'(b58enc_pkg::RECIP_MULT);
      quot = prod[b58enc_pkg::RECIP_SHIFT +: b58enc_pkg::QUOT_W];
      quot_scaled = b58enc_pkg::PART_W'(quot) * b58enc_pkg::PART_W'(b58enc_pkg::RADIX);
      rem = b58enc_pkg::DIGIT_W'(part - quot_scaled);
   end

   always_comb begin
      digit_in = digit_ff;
      if (ctrl.shift) begin
         digit_in = shift_in;
      end else if (carry_in.valid) begin
         digit_in = rem;
      end
      carry_in_next.valid = carry_in.valid && !ctrl.shift;
      carry_in_next.value = b58enc_pkg::CARRY_W'(digit_ff)
                          * b58enc_pkg::CARRY_W'(b58enc_pkg::BYTE_QUOT)
                          + b58enc_pkg::CARRY_W'(quot);
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         digit_ff <= '0;
         carry_ff <= '0;
      end else begin
         digit_ff <= digit_in;
         carry_ff <= carry_in_next;
      end
   end

   assign digit     = digit_ff;
   assign carry_out = carry_ff;

endmodule

// File: design/base58_encoder_unit.sv
// base58 encoder top level: byte intake, digit cell row, sequencer and response register
//
//   channel   direction  handshake        payload
//   req_chan  in         valid / ready    byte_value[7:0], last_byte
//   rsp_chan  out        valid / ready    character[6:0], last_char, status[1:0]
//   csr       in         csr_write_en     csr_write_data[6:0] (max output length)
//
// bytes are taken one per cycle while loading; each ripples through the digit cells
// after the last byte: drain of the carries, scan of the row for zero digits, length check,
// then leading zero digits skipped and one character per cycle while the response is free
// synchronous reset clears control state and all digit cells
// a stalled response holds the sequencer; requests wait until the last character is registered
module base58_encoder_unit (
   input  logic                               clock,
   input  logic                               reset,
   b58enc_req_if.sink                         req_chan,
   b58enc_rsp_if.source                       rsp_chan,
   input  logic                               csr_write_en,
   input  logic [b58enc_pkg::CFG_W-1:0]       csr_write_data
);

   typedef enum logic [6:0] {
      ST_LOAD   = 7'b0000001,
      ST_DRAIN  = 7'b0000010,
      ST_SCAN   = 7'b0000100,
      ST_CHECK  = 7'b0001000,
      ST_EMIT   = 7'b0010000,
      ST_FAULT  = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   localparam int ND = b58enc_pkg::NUM_DIGITS;

   state_type                                  state_ff, state_in;
   logic [b58enc_pkg::BYTE_CNT_W-1:0]          byte_cnt_ff, byte_cnt_in;
   logic                                       too_long_ff, too_long_in;
   logic                                       seen_nz_ff, seen_nz_in;
   logic [b58enc_pkg::BYTE_CNT_W-1:0]          lz_ff, lz_in;
   b58enc_pkg::carry_type                      feed_ff, feed_in;
   logic [b58enc_pkg::STEP_W-1:0]              step_ff, step_in;
   logic [b58enc_pkg::DIGIT_CNT_W-1:0]         zeros_ff, zeros_in;
   logic                                       found_ff, found_in;
   logic [b58enc_pkg::BYTE_CNT_W-1:0]          ones_left_ff, ones_left_in;
   logic [b58enc_pkg::DIGIT_CNT_W-1:0]         digits_left_ff, digits_left_in;
   logic [b58enc_pkg::DIGIT_CNT_W-1:0]         skip_ff, skip_in;
   logic [b58enc_pkg::CFG_W-1:0]               max_len_ff;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic [b58enc_pkg::CHAR_W-1:0]              rsp_char_ff, rsp_char_in;
   logic                                       rsp_last_ff, rsp_last_in;
   logic [b58enc_pkg::STATUS_W-1:0]            rsp_status_ff, rsp_status_in;

   b58enc_pkg::cell_ctrl_type                  cell_ctrl;
   b58enc_pkg::carry_type                      carries [ND+1];
   b58enc_pkg::digit_type                      digits [ND];
   logic                                       out_free;
   logic [b58enc_pkg::DIGIT_CNT_W-1:0]         digit_total;
   logic [b58enc_pkg::TOTAL_W-1:0]             char_total;

   assign carries[0] = feed_ff;

   for (genvar i = 0; i < ND; i++) begin : g_cell
      localparam int PREV = (i == 0) ? ND - 1 : i - 1;
      b58enc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .carry_in  (carries[i]),
         .shift_in  (digits[PREV]),
         .carry_out (carries[i+1]),
         .digit     (digits[i])
      );
   end

   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign digit_total = b58enc_pkg::DIGIT_CNT_W'(ND) - zeros_ff;
   assign char_total  = b58enc_pkg::TOTAL_W'(lz_ff) + b58enc_pkg::TOTAL_W'(digit_total);

   always_comb begin
      state_in       = state_ff;
      byte_cnt_in    = byte_cnt_ff;
      too_long_in    = too_long_ff;
      seen_nz_in     = seen_nz_ff;
      lz_in          = lz_ff;
      feed_in.valid  = 1'b0;
      feed_in.value  = feed_ff.value;
      step_in        = step_ff;
      zeros_in       = zeros_ff;
      found_in       = found_ff;
      ones_left_in   = ones_left_ff;
      digits_left_in = digits_left_ff;
      skip_in        = skip_ff;
      cell_ctrl      = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (req_chan.valid) begin
               if (byte_cnt_ff < b58enc_pkg::BYTE_CNT_W'(b58enc_pkg::MAX_INPUT_BYTES)) begin
                  feed_in.valid = 1'b1;
                  feed_in.value = req_chan.byte_value;
                  byte_cnt_in   = byte_cnt_ff + b58enc_pkg::BYTE_CNT_W'(1);
                  if (req_chan.byte_value == '0) begin
                     if (!seen_nz_ff) begin
                        lz_in = lz_ff + b58enc_pkg::BYTE_CNT_W'(1);
                     end
                  end else begin
                     seen_nz_in = 1'b1;
                  end
               end else begin
                  too_long_in = 1'b1;
               end
               if (req_chan.last_byte) begin
                  step_in  = '0;
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            step_in = step_ff + b58enc_pkg::STEP_W'(1);
            if (step_ff == b58enc_pkg::STEP_W'(ND)) begin
               step_in  = '0;
               zeros_in = '0;
               found_in = 1'b0;
               state_in = too_long_ff ? ST_FAULT : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // full rotation of the row, counting zero digits at the top
            cell_ctrl.shift = 1'b1;
            if (!found_ff) begin
               if (digits[ND-1] == '0) begin
                  zeros_in = zeros_ff + b58enc_pkg::DIGIT_CNT_W'(1);
               end else begin
                  found_in = 1'b1;
               end
            end
            step_in = step_ff + b58enc_pkg::STEP_W'(1);
            if (step_ff == b58enc_pkg::STEP_W'(ND - 1)) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (char_total > b58enc_pkg::TOTAL_W'(max_len_ff)) begin
               state_in = ST_FAULT;
            end else begin
               ones_left_in   = lz_ff;
               digits_left_in = digit_total;
               skip_in        = zeros_ff;
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip_ff != '0) begin
               cell_ctrl.shift = 1'b1;
               skip_in         = skip_ff - b58enc_pkg::DIGIT_CNT_W'(1);
            end else if (ones_left_ff != '0) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = b58enc_pkg::ASCII_ONE;
                  rsp_last_in   = (ones_left_ff == b58enc_pkg::BYTE_CNT_W'(1))
                                  && (digits_left_ff == '0);
                  rsp_status_in = b58enc_pkg::STATUS_OK;
                  ones_left_in  = ones_left_ff - b58enc_pkg::BYTE_CNT_W'(1);
               end
            end else if (digits_left_ff != '0) begin
               if (out_free) begin
                  cell_ctrl.shift = 1'b1;
                  rsp_valid_in    = 1'b1;
                  rsp_char_in     = b58enc_pkg::b58_char(digits[ND-1]);
                  rsp_last_in     = digits_left_ff == b58enc_pkg::DIGIT_CNT_W'(1);
                  rsp_status_in   = b58enc_pkg::STATUS_OK;
                  digits_left_in  = digits_left_ff - b58enc_pkg::DIGIT_CNT_W'(1);
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FAULT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = too_long_ff ? b58enc_pkg::STATUS_INPUT_LONG
                                           : b58enc_pkg::STATUS_OUTPUT_LONG;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cell_ctrl.clear = 1'b1;
            byte_cnt_in     = '0;
            too_long_in     = 1'b0;
            seen_nz_in      = 1'b0;
            lz_in           = '0;
            state_in        = ST_LOAD;
         end
         default: begin
            state_in = ST_FINISH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         byte_cnt_ff  <= '0;
         too_long_ff  <= 1'b0;
         seen_nz_ff   <= 1'b0;
         lz_ff        <= '0;
         feed_ff      <= '0;
         step_ff      <= '0;
         zeros_ff     <= '0;
         found_ff     <= 1'b0;
         ones_left_ff <= '0;
         digits_left_ff <= '0;
         skip_ff      <= '0;
         max_len_ff   <= b58enc_pkg::CFG_W'(b58enc_pkg::CFG_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         byte_cnt_ff  <= byte_cnt_in;
         too_long_ff  <= too_long_in;
         seen_nz_ff   <= seen_nz_in;
         lz_ff        <= lz_in;
         feed_ff      <= feed_in;
         step_ff      <= step_in;
         zeros_ff     <= zeros_in;
         found_ff     <= found_in;
         ones_left_ff <= ones_left_in;
         digits_left_ff <= digits_left_in;
         skip_ff      <= skip_in;
         if (csr_write_en) begin
            max_len_ff <= csr_write_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff   <= rsp_char_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_chan.ready     = state_ff == ST_LOAD;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.character = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;
   assign rsp_chan.status    = rsp_status_ff;

   // the row is long enough: nothing carries out of the top cell
   a_top_carry_zero: assert property (@(posedge clock) disable iff (reset)
      carries[ND].valid |-> carries[ND].value == '0)
      else $error("carry out of top digit cell");

   a_byte_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      byte_cnt_ff <= b58enc_pkg::BYTE_CNT_W'(b58enc_pkg::MAX_INPUT_BYTES))
      else $error("byte count beyond limit");

   a_feed_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(feed_ff.valid) |-> $past(state_ff) == ST_LOAD)
      else $error("byte fed outside of loading");

   a_emit_fits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |->
         b58enc_pkg::TOTAL_W'(ones_left_ff) + b58enc_pkg::TOTAL_W'(digits_left_ff)
         <= b58enc_pkg::TOTAL_W'(max_len_ff))
      else $error("emitting more characters than allowed");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != b58enc_pkg::STATUS_OK |-> rsp_last_ff)
      else $error("error response without last marker");

endmodule

// File: tb/tb_base58_encoder_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the base58 encoder unit: directed and random strings
module tb_base58_encoder_unit;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [b58enc_pkg::CHAR_W-1:0]   character;
      logic                            last_char;
      logic [b58enc_pkg::STATUS_W-1:0] status;
   } b58_char_type;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_en;
   logic [b58enc_pkg::CFG_W-1:0] csr_write_data;

   b58enc_req_if req_chan ();
   b58enc_rsp_if rsp_chan ();

   base58_encoder_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   string b58_alphabet = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   b58_char_type                  expected_chars[$];
   logic [b58enc_pkg::BYTE_W-1:0] string_bytes[$];
   bit                            string_overlong = 1'b0;
   logic [b58enc_pkg::CFG_W-1:0]  max_chars;
   int                            send_idle_pct = 0;
   int                            rsp_stall_pct = 0;
   int                            fail_count = 0;
   int                            cycle_count = 0;
   int                            string_count = 0;
   int                            byte_count = 0;
   int                            char_count = 0;
   int                            error_count = 0;

   always #4 clock = ~clock;

   function automatic void encode_string();
      int           work[$];
      int           digits[$];
      int           zeros;
      int           first;
      int           rem;
      int           acc;
      int           total;
      int           d;
      b58_char_type item;
      foreach (string_bytes[i]) work.push_back(int'(string_bytes[i]));
      zeros = 0;
      while (zeros < work.size() && work[zeros] == 0) zeros++;
      first = zeros;
      while (first < work.size()) begin
         rem = 0;
         for (int i = first; i < work.size(); i++) begin
            acc = rem * b58enc_pkg::BYTE_SPAN + work[i];
            work[i] = acc / b58enc_pkg::RADIX;
            rem = acc % b58enc_pkg::RADIX;
         end
         if (work[first] == 0) first++;
         digits.push_back(rem);
      end
      while (digits.size() > 0 && digits[$] == 0) digits.pop_back();
      total = zeros + digits.size();
      if (total > int'(max_chars)) begin
         item.character = '0;
         item.last_char = 1'b1;
         item.status    = b58enc_pkg::STATUS_OUTPUT_LONG;
         expected_chars.push_back(item);
      end else begin
         for (int p = 0; p < total; p++) begin
            d = (p < zeros) ? 0 : digits[total - 1 - p];
            item.character = b58enc_pkg::CHAR_W'(b58_alphabet[d]);
            item.last_char = (p == total - 1);
            item.status    = b58enc_pkg::STATUS_OK;
            expected_chars.push_back(item);
         end
      end
   endfunction

   function automatic void take_byte(input logic [b58enc_pkg::BYTE_W-1:0] value,
                                     input logic last);
      b58_char_type item;
      if (string_bytes.size() < b58enc_pkg::MAX_INPUT_BYTES) string_bytes.push_back(value);
      else string_overlong = 1'b1;
      byte_count++;
      if (last) begin
         string_count++;
         if (string_overlong) begin
            item.character = '0;
            item.last_char = 1'b1;
            item.status    = b58enc_pkg::STATUS_INPUT_LONG;
            expected_chars.push_back(item);
         end else begin
            encode_string();
         end
         string_bytes.delete();
         string_overlong = 1'b0;
      end
   endfunction

   task automatic send_byte(input logic [b58enc_pkg::BYTE_W-1:0] value, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.byte_value <= value;
      req_chan.last_byte  <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      take_byte(value, last);
   endtask

   task automatic send_string(input logic [b58enc_pkg::BYTE_W-1:0] str[$]);
      foreach (str[i]) send_byte(str[i], i == str.size() - 1);
   endtask

   task automatic pause_until_delivered();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
   endtask

   task automatic wait_idle();
      pause_until_delivered();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_chars(input logic [b58enc_pkg::CFG_W-1:0] value);
      wait_idle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      max_chars = value;
   endtask

   task automatic test_directed_values();
      send_string('{8'h00});
      send_string('{8'hff});
      send_string('{8'h39});
      pause_until_delivered();
      send_string('{8'h3a});
      send_string('{8'h00, 8'h00, 8'h01});
      send_string('{8'h00, 8'hff});
   endtask

   task automatic test_length_limits();
      write_max_chars(7'd1);
      send_string('{8'h00});
      send_string('{8'h3a});
      write_max_chars(7'd0);
      send_string('{8'h01});
      write_max_chars(7'd127);
      send_string('{8'hff, 8'hff, 8'hff});
   endtask

   task automatic test_random_strings(input int n_bytes, input int idle_pct,
                                      input int stall_pct,
                                      input logic [b58enc_pkg::CFG_W-1:0] limit);
      logic [b58enc_pkg::BYTE_W-1:0] str[$];
      int                            len;
      int                            zeros;
      int                            kind;
      int                            sent;
      write_max_chars(limit);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_bytes) begin
         kind = $urandom_range(99);
         if (kind < 60) len = $urandom_range(1, 8);
         else if (kind < 85) len = $urandom_range(9, b58enc_pkg::MAX_INPUT_BYTES - 1);
         else if (kind < 93) len = b58enc_pkg::MAX_INPUT_BYTES;
         else len = $urandom_range(b58enc_pkg::MAX_INPUT_BYTES + 1,
                                   b58enc_pkg::MAX_INPUT_BYTES + 8);
         zeros = ($urandom_range(4) == 0) ? $urandom_range(1, len) : 0;
         kind = $urandom_range(9);
         str.delete();
         for (int i = 0; i < len; i++) begin
            if (i < zeros) str.push_back(8'h00);
            else if (kind == 0) str.push_back(8'hff);
            else str.push_back(b58enc_pkg::BYTE_W'($urandom));
         end
         send_string(str);
         sent += len;
         if ($urandom_range(7) == 0) pause_until_delivered();
      end
   endtask

   always @(posedge clock) begin : rsp_check
      b58_char_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chars.size() == 0) begin
            $error("unexpected response: character %0h last_char %0b status %0d",
                   rsp_chan.character, rsp_chan.last_char, rsp_chan.status);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_chan.character !== want.character) begin
               $error("character: expected %0h, got %0h", want.character, rsp_chan.character);
               fail_count++;
            end
            if (rsp_chan.last_char !== want.last_char) begin
               $error("last_char: expected %0b, got %0b", want.last_char, rsp_chan.last_char);
               fail_count++;
            end
            if (rsp_chan.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
               fail_count++;
            end
            if (want.status == b58enc_pkg::STATUS_OK) char_count++;
            else error_count++;
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset               <= 1'b1;
      csr_write_en        <= 1'b0;
      csr_write_data      <= '0;
      req_chan.valid      <= 1'b0;
      req_chan.byte_value <= '0;
      req_chan.last_byte  <= 1'b0;
      max_chars = b58enc_pkg::CFG_W'(b58enc_pkg::CFG_RESET);
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      test_length_limits();
      test_random_strings(95, 0, 0, b58enc_pkg::CFG_W'(b58enc_pkg::CFG_RESET));
      test_random_strings(85, 65, 0, 7'd127);
      test_random_strings(85, 0, 65, b58enc_pkg::CFG_W'($urandom_range(4, 20)));
      test_random_strings(105, 28, 28, 7'd44);
      wait_idle();

      $display("encoded %0d strings from %0d bytes, limits 0 to 127, with idle and stall mixes",
               string_count, byte_count);
      $display("checked %0d characters and %0d error responses", char_count, error_count);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
